// ----- sv/glb_cs_pkg.sv -----
// Shared constants and types for the GLB chunk splitter.
// No dependencies; used by glb_cs_out_fifo and glb_chunk_splitter_top.
package glb_cs_pkg;

	// Width of the chunk payload byte counter (16..32)
	localparam int LENGTH_BITS = 32;

	localparam logic [31:0] GLB_MAGIC  = 32'h4654_6C67;
	localparam logic [31:0] CHUNK_JSON = 32'h4E4F_534A;
	localparam logic [31:0] CHUNK_BIN  = 32'h004E_4942;

	localparam logic [3:0] FILE_HDR_LAST  = 4'd11;  // index of final file header byte
	localparam logic [3:0] CHUNK_HDR_LAST = 4'd7;   // index of final chunk header byte
	localparam logic [3:0] MAGIC_BYTES    = 4'd4;

	// parser phases
	localparam logic [2:0] PH_FILE_HDR  = 3'd0;
	localparam logic [2:0] PH_FIRST_HDR = 3'd1;
	localparam logic [2:0] PH_CHUNK_HDR = 3'd2;
	localparam logic [2:0] PH_PAYLOAD   = 3'd3;
	localparam logic [2:0] PH_IGNORE    = 3'd4;

	// payload routing
	localparam logic [1:0] ROUTE_SKIP = 2'd0;
	localparam logic [1:0] ROUTE_JSON = 2'd1;
	localparam logic [1:0] ROUTE_BIN  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_JSON   = 2'd0;
	localparam logic [1:0] KIND_BIN    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_GLB   = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_NO_JSON   = 2'd3;

	// output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	// up to two results per input byte, compacted: first_item is written first
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first_item;
		out_item_t  second_item;
	} push_req_t;

endpackage

// ----- sv/glb_chunk_splitter_top.sv -----
// Top level of the GLB chunk splitter: byte parser and result queue.
// Depends on glb_cs_pkg and glb_cs_out_fifo.
//
// Takes a binary glTF file one byte per transfer (end_of_file on the final
// byte), checks the "glTF" magic in the 12-byte file header, then walks the
// 8-byte chunk headers. Payload bytes of the first JSON chunk come out with
// kind JSON, those of the first non-empty BIN chunk with kind BIN; every other
// chunk is dropped. The final byte of a file also yields one status transfer
// (kind STATUS, last=1): ok, not glb, truncated chunk or no JSON chunk, after
// which the parser rearms for the next file. Bytes already forwarded are never
// retracted. Rate: one input byte per cycle; the parser is combinational and feeds
// a 4-entry result queue, which registers the results. The output side moves
// one transfer per cycle while out_stall is low, and the final byte of a file
// can produce two transfers; the input stalls only when the queue cannot take
// two more results.
module glb_chunk_splitter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       end_of_file,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] payload,
	output logic [1:0] status,
	output logic       last
);

	localparam int LB = glb_cs_pkg::LENGTH_BITS;

	// parser state
	logic [2:0]    phase_q;
	logic [3:0]    hdr_cnt_q;     // byte index inside file/chunk header
	logic          magic_good_q;
	logic [55:0]   hdr_shift_q;   // previous 7 chunk header bytes, little endian
	logic [LB-1:0] bytes_left_q;
	logic [1:0]    route_q;
	logic          json_taken_q;
	logic          bin_taken_q;

	// next-state values
	logic [2:0]    phase_d;
	logic [3:0]    hdr_cnt_d;
	logic          magic_good_d;
	logic [55:0]   hdr_shift_d;
	logic [LB-1:0] bytes_left_d;
	logic [1:0]    route_d;
	logic          json_taken_d;
	logic          bin_taken_d;

	logic          accept;
	logic          emit_payload;
	logic [1:0]    emit_kind;
	logic [1:0]    final_status;
	logic [31:0]   hdr_len;
	logic [31:0]   hdr_type;
	logic          len_oversize;
	logic [LB-1:0] left_dec;
	logic [7:0]    magic_byte;

	glb_cs_pkg::push_req_t push;
	glb_cs_pkg::out_item_t pay_item;
	glb_cs_pkg::out_item_t stat_item;
	glb_cs_pkg::out_item_t head;
	logic                  q_not_empty;
	logic                  q_room;
	logic                  pop;

	assign accept   = in_valid && !in_stall;
	assign in_stall = !q_room;

	// full chunk header once the eighth byte arrives
	assign hdr_len      = hdr_shift_q[31:0];
	assign hdr_type     = {byte_in, hdr_shift_q[55:32]};
	assign len_oversize = ((hdr_len >> LB) != 32'd0);
	assign left_dec     = (bytes_left_q != '0) ? (bytes_left_q - LB'(1)) : bytes_left_q;
	assign magic_byte   = glb_cs_pkg::GLB_MAGIC[{hdr_cnt_q[1:0], 3'b000} +: 8];

	always_comb begin
		phase_d      = phase_q;
		hdr_cnt_d    = hdr_cnt_q;
		magic_good_d = magic_good_q;
		hdr_shift_d  = hdr_shift_q;
		bytes_left_d = bytes_left_q;
		route_d      = route_q;
		json_taken_d = json_taken_q;
		bin_taken_d  = bin_taken_q;
		emit_payload = 1'b0;
		emit_kind    = glb_cs_pkg::KIND_JSON;
		final_status = glb_cs_pkg::ST_OK;

		unique case (phase_q) inside
			glb_cs_pkg::PH_FILE_HDR: begin
				if (hdr_cnt_q < glb_cs_pkg::MAGIC_BYTES && byte_in != magic_byte) begin
					magic_good_d = 1'b0;
				end
				hdr_cnt_d = hdr_cnt_q + 4'd1;
				if (hdr_cnt_q == glb_cs_pkg::FILE_HDR_LAST) begin
					hdr_cnt_d   = '0;
					hdr_shift_d = '0;
					phase_d     = magic_good_d ? glb_cs_pkg::PH_FIRST_HDR
						: glb_cs_pkg::PH_IGNORE;
				end
			end
			glb_cs_pkg::PH_FIRST_HDR, glb_cs_pkg::PH_CHUNK_HDR: begin
				hdr_shift_d = {byte_in, hdr_shift_q[55:8]};
				hdr_cnt_d   = hdr_cnt_q + 4'd1;
				if (hdr_cnt_q == glb_cs_pkg::CHUNK_HDR_LAST) begin
					hdr_cnt_d   = '0;
					hdr_shift_d = '0;
					if (len_oversize) begin
						phase_d = glb_cs_pkg::PH_IGNORE;
						route_d = glb_cs_pkg::ROUTE_SKIP;
					end else begin
						if (hdr_type == glb_cs_pkg::CHUNK_JSON && !json_taken_q) begin
							route_d      = glb_cs_pkg::ROUTE_JSON;
							json_taken_d = 1'b1;
						end else if (hdr_type == glb_cs_pkg::CHUNK_BIN && !bin_taken_q
							&& hdr_len != 32'd0) begin
							route_d     = glb_cs_pkg::ROUTE_BIN;
							bin_taken_d = 1'b1;
						end else begin
							route_d = glb_cs_pkg::ROUTE_SKIP;
						end
						bytes_left_d = hdr_len[LB-1:0];
						phase_d      = (hdr_len != 32'd0) ? glb_cs_pkg::PH_PAYLOAD
							: glb_cs_pkg::PH_CHUNK_HDR;
					end
				end
			end
			glb_cs_pkg::PH_PAYLOAD: begin
				if (route_q == glb_cs_pkg::ROUTE_JSON) begin
					emit_payload = 1'b1;
					emit_kind    = glb_cs_pkg::KIND_JSON;
				end else if (route_q == glb_cs_pkg::ROUTE_BIN) begin
					emit_payload = 1'b1;
					emit_kind    = glb_cs_pkg::KIND_BIN;
				end
				bytes_left_d = left_dec;
				if (left_dec == '0) begin
					phase_d     = glb_cs_pkg::PH_CHUNK_HDR;
					hdr_cnt_d   = '0;
					hdr_shift_d = '0;
					route_d     = glb_cs_pkg::ROUTE_SKIP;
				end
			end
			default: begin
				phase_d = glb_cs_pkg::PH_IGNORE;
			end
		endcase

		// status from the state this byte leaves behind
		if (phase_d == glb_cs_pkg::PH_FILE_HDR || phase_d == glb_cs_pkg::PH_FIRST_HDR) begin
			final_status = glb_cs_pkg::ST_NOT_GLB;
		end else if (phase_d == glb_cs_pkg::PH_IGNORE) begin
			final_status = magic_good_d ? glb_cs_pkg::ST_TRUNCATED
				: glb_cs_pkg::ST_NOT_GLB;
		end else if (phase_d == glb_cs_pkg::PH_PAYLOAD) begin
			final_status = glb_cs_pkg::ST_TRUNCATED;
		end else begin
			final_status = json_taken_d ? glb_cs_pkg::ST_OK : glb_cs_pkg::ST_NO_JSON;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= glb_cs_pkg::PH_FILE_HDR;
			hdr_cnt_q    <= '0;
			magic_good_q <= 1'b1;
			hdr_shift_q  <= '0;
			bytes_left_q <= '0;
			route_q      <= glb_cs_pkg::ROUTE_SKIP;
			json_taken_q <= 1'b0;
			bin_taken_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_file) begin
				// rearm for the next file
				phase_q      <= glb_cs_pkg::PH_FILE_HDR;
				hdr_cnt_q    <= '0;
				magic_good_q <= 1'b1;
				hdr_shift_q  <= '0;
				bytes_left_q <= '0;
				route_q      <= glb_cs_pkg::ROUTE_SKIP;
				json_taken_q <= 1'b0;
				bin_taken_q  <= 1'b0;
			end else begin
				phase_q      <= phase_d;
				hdr_cnt_q    <= hdr_cnt_d;
				magic_good_q <= magic_good_d;
				hdr_shift_q  <= hdr_shift_d;
				bytes_left_q <= bytes_left_d;
				route_q      <= route_d;
				json_taken_q <= json_taken_d;
				bin_taken_q  <= bin_taken_d;
			end
		end
	end

	// result items; payload item (if any) goes ahead of the status item
	always_comb begin
		pay_item.kind    = emit_kind;
		pay_item.payload = byte_in;
		pay_item.status  = glb_cs_pkg::ST_OK;
		pay_item.last    = 1'b0;

		stat_item.kind    = glb_cs_pkg::KIND_STATUS;
		stat_item.payload = 8'd0;
		stat_item.status  = final_status;
		stat_item.last    = 1'b1;

		push.first_item  = emit_payload ? pay_item : stat_item;
		push.second_item = stat_item;
		push.count       = accept ? (2'(emit_payload) + 2'(end_of_file)) : 2'd0;
	end

	assign pop = out_valid && !out_stall;

	glb_cs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.not_empty (q_not_empty),
		.has_room  (q_room),
		.head      (head)
	);

	assign out_valid = q_not_empty;
	assign kind      = head.kind;
	assign payload   = head.payload;
	assign status    = head.status;
	assign last      = head.last;

	a_rearm_after_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_file) |=>
		(phase_q == glb_cs_pkg::PH_FILE_HDR && hdr_cnt_q == '0 && !json_taken_q))
		else $error("parser did not rearm after end of file");

	a_payload_only_in_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		emit_payload |-> (phase_q == glb_cs_pkg::PH_PAYLOAD && bytes_left_q != '0))
		else $error("payload emitted outside a counted chunk");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == glb_cs_pkg::KIND_STATUS) == last))
		else $error("last flag does not match status item");

endmodule

// ----- sv/glb_cs_out_fifo.sv -----
// Result queue for the GLB chunk splitter: takes up to two items a cycle,
// hands out one. Depends on glb_cs_pkg.
module glb_cs_out_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  glb_cs_pkg::push_req_t push,
	input  logic                  pop,
	output logic                  not_empty,
	output logic                  has_room,
	output glb_cs_pkg::out_item_t head
);

	glb_cs_pkg::out_item_t              mem_q [glb_cs_pkg::FIFO_DEPTH];
	logic [glb_cs_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [glb_cs_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [glb_cs_pkg::FIFO_CW-1:0]     count_q;
	logic [glb_cs_pkg::FIFO_AW-1:0]     wr_ptr_next;

	assign wr_ptr_next = wr_ptr_q + glb_cs_pkg::FIFO_AW'(1);
	assign not_empty   = (count_q != '0);
	// room for a full two-item push
	assign has_room    = (count_q <= glb_cs_pkg::FIFO_CW'(glb_cs_pkg::FIFO_DEPTH - 2));
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first_item;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_next] <= push.second_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + glb_cs_pkg::FIFO_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + glb_cs_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + glb_cs_pkg::FIFO_CW'(push.count)
				- glb_cs_pkg::FIFO_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + glb_cs_pkg::FIFO_CW'(push.count) - glb_cs_pkg::FIFO_CW'(pop))
		<= glb_cs_pkg::FIFO_CW'(glb_cs_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue popped while empty");

endmodule

// ----- verif/glb_chunk_splitter_top_tb.sv -----
// Self-checking testbench for glb_chunk_splitter_top: GLB files in, tagged bytes and status out.
// Depends on glb_cs_pkg and the RTL under sv/; results are predicted in place, byte by byte.
`timescale 1ns / 1ps

module glb_chunk_splitter_top_tb;
	import glb_cs_pkg::*;

	localparam int CYCLE_LIMIT  = 500_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 100;   // long receiver hold-off
	localparam int ITEM_TARGET  = 1550;  // input bytes for the whole run

	// chunk type that is neither JSON nor BIN
	localparam logic [31:0] OTHER_TYPE = 32'h1234_5678;

	// One test file: header, up to three chunks, optionally cut short.
	typedef struct packed {
		logic             magic_ok;
		logic [1:0]       n_chunks;
		logic [0:2][31:0] ctype;
		logic [0:2][31:0] clen;
		logic [15:0]      keep;      // bytes kept from the front, 0 keeps the whole file
		logic             st_given;  // status filled in by hand
		logic [1:0]       st;
	} glb_case_t;

	// Per-file note for the status prediction, queued before the file goes out.
	typedef struct packed {
		logic       given;
		logic [1:0] st;
	} status_note_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] byte_in;
	logic       end_of_file;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] kind;
	logic [7:0] payload;
	logic [1:0] status;
	logic       last;

	glb_chunk_splitter_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.byte_in     (byte_in),
		.end_of_file (end_of_file),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.payload     (payload),
		.status      (status),
		.last        (last)
	);

	// Directed files. Status typed in where it is obvious, else left to the predictor.
	glb_case_t dir_cases [16] = '{
		// header only: first chunk header never starts -> not glb
		'{1'b1, 2'd0, '{'0, '0, '0}, '{'0, '0, '0}, 16'd0, 1'b1, ST_NOT_GLB},
		// one byte short of a full first chunk header
		'{1'b1, 2'd1, '{CHUNK_JSON, '0, '0}, '{32'd4, '0, '0}, 16'd19, 1'b1, ST_NOT_GLB},
		// single-byte file
		'{1'b1, 2'd0, '{'0, '0, '0}, '{'0, '0, '0}, 16'd1, 1'b1, ST_NOT_GLB},
		// bad magic, chunk behind it must be dropped
		'{1'b0, 2'd1, '{CHUNK_JSON, '0, '0}, '{32'd4, '0, '0}, 16'd0, 1'b1, ST_NOT_GLB},
		'{1'b1, 2'd1, '{CHUNK_JSON, '0, '0}, '{32'd4, '0, '0}, 16'd0, 1'b1, ST_OK},
		// empty JSON still counts as the JSON chunk
		'{1'b1, 2'd2, '{CHUNK_JSON, CHUNK_BIN, '0}, '{32'd0, 32'd3, '0}, 16'd0, 1'b1, ST_OK},
		// empty BIN is skipped and does not use up the BIN slot
		'{1'b1, 2'd3, '{CHUNK_BIN, CHUNK_BIN, CHUNK_JSON}, '{32'd0, 32'd2, 32'd1},
			16'd0, 1'b0, ST_OK},
		'{1'b1, 2'd1, '{CHUNK_BIN, '0, '0}, '{32'd3, '0, '0}, 16'd0, 1'b1, ST_NO_JSON},
		// cut in the middle of the JSON payload
		'{1'b1, 2'd1, '{CHUNK_JSON, '0, '0}, '{32'd6, '0, '0}, 16'd23, 1'b1, ST_TRUNCATED},
		// partial chunk header at the end is ignored
		'{1'b1, 2'd2, '{CHUNK_JSON, OTHER_TYPE, '0}, '{32'd2, 32'd5, '0}, 16'd25, 1'b1, ST_OK},
		// second JSON is skipped
		'{1'b1, 2'd3, '{CHUNK_JSON, CHUNK_JSON, CHUNK_BIN}, '{32'd2, 32'd2, 32'd2},
			16'd0, 1'b0, ST_OK},
		// largest length, forwarded bytes stay out
		'{1'b1, 2'd1, '{CHUNK_JSON, '0, '0}, '{'1, '0, '0}, 16'd26, 1'b1, ST_TRUNCATED},
		'{1'b1, 2'd2, '{'1, CHUNK_JSON, '0}, '{32'd3, 32'd0, '0}, 16'd0, 1'b0, ST_OK},
		// file ends right on a complete header with nonzero length
		'{1'b1, 2'd1, '{CHUNK_JSON, '0, '0}, '{32'd4, '0, '0}, 16'd20, 1'b1, ST_TRUNCATED},
		'{1'b1, 2'd1, '{CHUNK_BIN, '0, '0}, '{'1, '0, '0}, 16'd30, 1'b1, ST_TRUNCATED},
		// all-zero chunk header, then a one-byte JSON
		'{1'b1, 2'd2, '{'0, CHUNK_JSON, '0}, '{'0, 32'd1, '0}, 16'd0, 1'b0, ST_OK}
	};

	// Predictor state
	logic [2:0]  ps_phase;
	logic [4:0]  hdr_idx;
	logic        magic_ok;
	logic [63:0] hdr_bits;
	logic [31:0] remain;
	logic [1:0]  route;
	logic        json_seen;
	logic        bin_seen;

	out_item_t    result_q [$];     // expected output transfers, oldest first
	status_note_t status_notes [$];
	logic [7:0]   file_bytes [$];   // file being sent

	int  tx_mode;
	int  rx_mode;
	bit  hold_req;
	int  cycles;
	int  errors;
	int  n_files;
	int  n_bytes;
	int  n_json;
	int  n_bin;
	int  n_status;
	int  held_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic queue_result(input out_item_t it);
		result_q.insert(result_q.size(), it);
	endtask

	task automatic rearm();
		ps_phase  = PH_FILE_HDR;
		hdr_idx   = '0;
		magic_ok  = 1'b1;
		hdr_bits  = '0;
		remain    = '0;
		route     = ROUTE_SKIP;
		json_seen = 1'b0;
		bin_seen  = 1'b0;
	endtask

	// Advance the predictor by one accepted byte and queue what it produces.
	task automatic predict_byte(input logic [7:0] b, input logic eof);
		logic [31:0]  len;
		logic [31:0]  typ;
		logic [1:0]   st;
		status_note_t note;

		case (ps_phase) inside
		PH_FILE_HDR: begin
			if (hdr_idx < MAGIC_BYTES && b != GLB_MAGIC[8*hdr_idx +: 8])
				magic_ok = 1'b0;
			if (hdr_idx == FILE_HDR_LAST) begin
				hdr_idx  = '0;
				hdr_bits = '0;
				ps_phase = magic_ok ? PH_FIRST_HDR : PH_IGNORE;
			end else
				hdr_idx++;
		end
		PH_FIRST_HDR, PH_CHUNK_HDR: begin
			// little endian: length lands in the low word, type in the high word
			hdr_bits = {b, hdr_bits[63:8]};
			if (hdr_idx == CHUNK_HDR_LAST) begin
				len      = hdr_bits[31:0];
				typ      = hdr_bits[63:32];
				hdr_idx  = '0;
				hdr_bits = '0;
				if ((len >> LENGTH_BITS) != 0) begin
					ps_phase = PH_IGNORE;
					route    = ROUTE_SKIP;
				end else begin
					if (typ == CHUNK_JSON && !json_seen) begin
						route     = ROUTE_JSON;
						json_seen = 1'b1;
					end else if (typ == CHUNK_BIN && !bin_seen && len != 0) begin
						route    = ROUTE_BIN;
						bin_seen = 1'b1;
					end else
						route = ROUTE_SKIP;
					remain   = len;
					ps_phase = (len != 0) ? PH_PAYLOAD : PH_CHUNK_HDR;
				end
			end else
				hdr_idx++;
		end
		PH_PAYLOAD: begin
			if (route == ROUTE_JSON)
				queue_result({KIND_JSON, b, ST_OK, 1'b0});
			else if (route == ROUTE_BIN)
				queue_result({KIND_BIN, b, ST_OK, 1'b0});
			if (remain != 0)
				remain--;
			if (remain == 0) begin
				ps_phase = PH_CHUNK_HDR;
				hdr_idx  = '0;
				hdr_bits = '0;
				route    = ROUTE_SKIP;
			end
		end
		default: ps_phase = PH_IGNORE;
		endcase

		if (eof) begin
			note = (status_notes.size() != 0) ? status_notes.pop_front() : '0;
			if (ps_phase == PH_FILE_HDR || ps_phase == PH_FIRST_HDR)
				st = ST_NOT_GLB;
			else if (ps_phase == PH_IGNORE)
				st = magic_ok ? ST_TRUNCATED : ST_NOT_GLB;
			else if (ps_phase == PH_PAYLOAD)
				st = ST_TRUNCATED;
			else
				st = json_seen ? ST_OK : ST_NO_JSON;
			if (note.given)
				st = note.st;
			queue_result({KIND_STATUS, 8'h00, st, 1'b1});
			rearm();
		end
	endtask

	// Compare one accepted output transfer with the oldest expectation.
	task automatic check_result();
		out_item_t want;

		if (result_q.size() == 0) begin
			flag_error($sformatf("unexpected transfer kind %0d payload %02h status %0d last %0d",
				kind, payload, status, last));
			return;
		end
		want = result_q.pop_front();
		if (kind !== want.kind)
			flag_error($sformatf("kind %0d, want %0d", kind, want.kind));
		if (payload !== want.payload)
			flag_error($sformatf("payload %02h, want %02h", payload, want.payload));
		if (status !== want.status)
			flag_error($sformatf("status %0d, want %0d", status, want.status));
		if (last !== want.last)
			flag_error($sformatf("last %0d, want %0d", last, want.last));
		case (want.kind)
		KIND_JSON: n_json++;
		KIND_BIN:  n_bin++;
		default:   n_status++;
		endcase
	endtask

	// Both handshakes are sampled at the rising edge; the input is predicted first so a
	// same-cycle result would still find its expectation.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			predict_byte(byte_in, end_of_file);
		if (arst_n && out_valid && !out_stall)
			check_result();
		if (arst_n && in_valid && in_stall)
			held_cycles++;
	end

	// Wait draw: 0 never idles, 1 idles now and then, 2 draws a fresh wait for every transfer.
	function automatic int draw_wait(input int mode);
		case (mode)
		0:       return 0;
		1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		default: return $urandom_range(0, 18);
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
		0:       return 8'h00;
		1:       return 8'hFF;
		default: return 8'($urandom());
		endcase
	endfunction

	task automatic add_word(input logic [31:0] w);
		for (int j = 0; j < 4; j++)
			file_bytes.insert(file_bytes.size(), w[8*j +: 8]);
	endtask

	// Lay out a file from its recipe: header, chunk headers, random payload, then cut.
	task automatic build_file(input glb_case_t c);
		int cap;

		file_bytes.delete();
		cap = (c.keep == 0) ? 32'h7FFF_FFFF : int'(c.keep);
		add_word(c.magic_ok ? GLB_MAGIC : GLB_MAGIC ^ (32'd1 << $urandom_range(0, 31)));
		add_word(32'd2);       // version, not checked by the block
		add_word($urandom());  // total length, not checked either
		for (int i = 0; i < int'(c.n_chunks); i++) begin
			add_word(c.clen[i]);
			add_word(c.ctype[i]);
			for (longint k = 0; k < longint'(c.clen[i]) && file_bytes.size() < cap; k++)
				file_bytes.insert(file_bytes.size(), rand_byte());
		end
		while (file_bytes.size() > cap)
			void'(file_bytes.pop_back());
	endtask

	// One input transfer. Valid changes only at the falling edge, and only once per edge.
	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;

		gap = draw_wait(tx_mode);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		byte_in     <= b;
		end_of_file <= eof;
		do @(posedge clk); while (in_stall);
		n_bytes++;
	endtask

	task automatic send_file(input logic given, input logic [1:0] st);
		status_note_t note;

		note.given = given;
		note.st    = st;
		status_notes.insert(status_notes.size(), note);
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], 1'(i == file_bytes.size() - 1));
		n_files++;
	endtask

	// Receiver: per transfer a random stall, or the long hold-off when asked for.
	initial begin : rx_side
		int n;

		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				n        = HOLD_CYCLES;
				hold_req = 1'b0;
			end else
				n = draw_wait(rx_mode);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d transfers still expected",
			cycles, result_q.size());
		$display("glb_chunk_splitter_top_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		glb_case_t c;
		int        full;
		logic      huge;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		byte_in     = '0;
		end_of_file = 1'b0;
		hold_req    = 1'b0;
		tx_mode     = 0;
		rx_mode     = 0;
		rearm();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed files
		foreach (dir_cases[i]) begin
			tx_mode = $urandom_range(0, 2);
			rx_mode = $urandom_range(0, 2);
			build_file(dir_cases[i]);
			send_file(dir_cases[i].st_given, dir_cases[i].st);
		end

		// Back pressure: bytes arrive back to back while the receiver sits on its stall,
		// so the result queue fills and the input has to stall.
		tx_mode  = 0;
		rx_mode  = 0;
		c        = '{1'b1, 2'd1, '{CHUNK_JSON, '0, '0}, '{32'd64, '0, '0}, 16'd0, 1'b1, ST_OK};
		hold_req = 1'b1;
		build_file(c);
		send_file(c.st_given, c.st);

		// Random files: mostly well formed with random content, some broken, some noise.
		while (n_bytes < ITEM_TARGET) begin
			tx_mode = $urandom_range(0, 2);
			rx_mode = $urandom_range(0, 2);
			if ($urandom_range(0, 11) == 0) begin
				file_bytes.delete();
				repeat ($urandom_range(1, 40))
					file_bytes.insert(file_bytes.size(), rand_byte());
				send_file(1'b0, ST_OK);
			end else begin
				c          = '0;
				c.magic_ok = ($urandom_range(0, 9) != 0);
				c.n_chunks = 2'($urandom_range(0, 3));
				full       = 12 + 8 * int'(c.n_chunks);
				huge       = 1'b0;
				for (int i = 0; i < int'(c.n_chunks); i++) begin
					case ($urandom_range(0, 9)) inside
					[0:3]:   c.ctype[i] = CHUNK_JSON;
					[4:7]:   c.ctype[i] = CHUNK_BIN;
					8:       c.ctype[i] = $urandom();
					default: c.ctype[i] = CHUNK_JSON ^ (32'd1 << $urandom_range(0, 31));
					endcase
					case ($urandom_range(0, 15))
					0:       c.clen[i] = '0;
					1: begin
						// huge length: the file is cut to at most 160 bytes
						c.clen[i] = $urandom();
						huge      = 1'b1;
					end
					2:       c.clen[i] = $urandom_range(41, 160);
					default: c.clen[i] = $urandom_range(1, 40);
					endcase
					if (!huge)
						full += int'(c.clen[i]);
				end
				if (huge)
					c.keep = 16'($urandom_range(1, 160));
				else if ($urandom_range(0, 3) == 0)
					c.keep = 16'($urandom_range(1, full));
				build_file(c);
				send_file(1'b0, ST_OK);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then give a late extra transfer a chance to show up.
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d files in %0d bytes; checked %0d JSON, %0d BIN, %0d status transfers",
			n_files, n_bytes, n_json, n_bin, n_status);
		$display("Input held back by a full result queue for %0d cycles; %0d mismatches",
			held_cycles, errors);
		if (errors == 0)
			$display("glb_chunk_splitter_top_tb OK");
		else
			$display("glb_chunk_splitter_top_tb NOT OK");
		$finish;
	end

endmodule
